// ----- rtl/core/ism_pkg.sv -----
// ----------------------------------------------------------------------------
// Idle sine modulator package
// Field widths, register and step codes, microcode and constant tables.
// ----------------------------------------------------------------------------
package ism_pkg;

    // phase and sine geometry
    localparam int PHASE_BITS   = 16;
    localparam int SINE_ENTRIES = 256;
    localparam int WARM_TEMP    = 60;
    localparam int SINE_BITS    = $clog2(SINE_ENTRIES);
    localparam int QTR_SIZE     = SINE_ENTRIES / 4;
    localparam int QTR_ENTRIES  = QTR_SIZE + 1;
    localparam int QTR_BITS     = $clog2(QTR_ENTRIES);
    localparam int Q_W          = 15;

    // item fields
    localparam int RPM_W    = 14;
    localparam int TPS_W    = 7;
    localparam int CLT_W    = 9;
    localparam int EFFECT_W = 16;
    localparam int TIMING_W = 13;
    localparam int FUEL_W   = 15;

    // configuration registers
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int AMP_W      = 7;
    localparam int PERIOD_W   = 5;
    localparam int TSPAN_W    = 5;
    localparam int FSPAN_W    = 6;
    localparam int RPMLIM_W   = 11;
    localparam int TPSLIM_W   = 5;
    localparam int PERIOD_COUNT = 1 << PERIOD_W;

    localparam int AMP_MAX   = 100;
    localparam int TSPAN_MAX = 10;
    localparam int FSPAN_MAX = 20;
    localparam int TSPAN_MAG_W = 4;
    localparam int FSPAN_MAG_W = 5;

    // shared multiplier and the divide-by-100 reciprocal (exact for inputs below 2^22)
    localparam int MUL_A_W    = 22;
    localparam int MUL_B_W    = 23;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int DIV_SHIFT  = 29;
    localparam int DIV100_MUL = 5368710;
    localparam int BIAS_100   = 50;
    localparam int BIAS_200   = 100;
    localparam int TIM_BIAS   = 64;
    localparam int TIM_SHIFT  = 7;
    localparam int TIM_PROD_W = 19;
    localparam int FUEL_PROD_W = 21;
    localparam int FUEL_NEUTRAL = 16384;
    // smallest magnitude with 10 * mag > 7 * 32768
    localparam int SKIP_MAG_MIN = (7 * 32768) / 10 + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RUMBLE_ENABLE,
        REG_AMPLITUDE,
        REG_PERIOD,
        REG_METHOD,
        REG_TIMING_SPAN,
        REG_FUEL_SPAN,
        REG_RPM_LIMIT,
        REG_THROTTLE_LIMIT
    } t_reg_idx;

    typedef enum logic [1:0] {
        METH_TIMING,
        METH_FUEL,
        METH_SPARK,
        METH_BOTH
    } t_method;

    // microcode
    typedef enum logic [2:0] {
        ST_CHECK,
        ST_AMP,
        ST_DIV,
        ST_TIM,
        ST_FSPAN,
        ST_FDIV,
        ST_FUEL,
        ST_EMIT
    } t_step;

    typedef enum logic [2:0] {
        A_SINE,
        A_RND100,
        A_QUO,
        A_MAG,
        A_RND200
    } t_asel;

    typedef enum logic [1:0] {
        B_AMP,
        B_RECIP,
        B_TSPAN,
        B_FSPAN
    } t_bsel;

    typedef enum logic [1:0] {
        C_NONE,
        C_NOT_IDLE,
        C_NO_FUEL
    } t_cond;

    typedef struct packed {
        t_asel asel;
        t_bsel bsel;
        logic  mul_en;
        logic  ld_phase;
        logic  ld_sign;
        logic  ld_mag;
        logic  ld_tim;
        logic  ld_fuel;
        logic  emit;
        t_cond cond;
        t_step target;
    } t_uop;

    function automatic t_uop uop_rom(t_step s);
        t_uop u;
        u = '{asel: A_SINE, bsel: B_AMP, mul_en: 1'b0, ld_phase: 1'b0, ld_sign: 1'b0,
              ld_mag: 1'b0, ld_tim: 1'b0, ld_fuel: 1'b0, emit: 1'b0, cond: C_NONE,
              target: ST_CHECK};
        unique case (s)
            ST_CHECK: begin
                u.ld_phase = 1'b1;
                u.cond     = C_NOT_IDLE;
                u.target   = ST_EMIT;
            end
            ST_AMP: begin
                u.asel    = A_SINE;
                u.bsel    = B_AMP;
                u.mul_en  = 1'b1;
                u.ld_sign = 1'b1;
            end
            ST_DIV: begin
                u.asel   = A_RND100;
                u.bsel   = B_RECIP;
                u.mul_en = 1'b1;
            end
            ST_TIM: begin
                u.asel   = A_QUO;
                u.bsel   = B_TSPAN;
                u.mul_en = 1'b1;
                u.ld_mag = 1'b1;
            end
            ST_FSPAN: begin
                u.asel   = A_MAG;
                u.bsel   = B_FSPAN;
                u.mul_en = 1'b1;
                u.ld_tim = 1'b1;
                u.cond   = C_NO_FUEL;
                u.target = ST_EMIT;
            end
            ST_FDIV: begin
                u.asel   = A_RND200;
                u.bsel   = B_RECIP;
                u.mul_en = 1'b1;
            end
            ST_FUEL: begin
                u.ld_fuel = 1'b1;
            end
            ST_EMIT: begin
                u.emit = 1'b1;
            end
        endcase
        return u;
    endfunction

    // phase increment per period setting: round(2^PHASE_BITS / (10 * period)),
    // period zero taken as one; shift-subtract division at elaboration
    function automatic logic [PERIOD_COUNT*PHASE_BITS-1:0] build_step_lut();
        logic [PERIOD_COUNT*PHASE_BITS-1:0] lut;
        logic [31:0] num;
        logic [31:0] den;
        logic [31:0] rem;
        logic [31:0] quo;
        int per;
        lut = '0;
        for (int p = 0; p < PERIOD_COUNT; p++) begin
            per = (p == 0) ? 1 : p;
            den = 32'(10 * per);
            num = 32'((1 << PHASE_BITS) + 5 * per);
            rem = '0;
            quo = '0;
            for (int b = 31; b >= 0; b--) begin
                rem = {rem[30:0], num[b]};
                if (rem >= den) begin
                    rem    = rem - den;
                    quo[b] = 1'b1;
                end
            end
            lut[p*PHASE_BITS +: PHASE_BITS] = quo[PHASE_BITS-1:0];
        end
        return lut;
    endfunction

    // quarter-wave sine magnitudes, odd Taylor series of degree 9 in Q30
    function automatic logic [QTR_ENTRIES*Q_W-1:0] build_sine_qtr();
        logic [QTR_ENTRIES*Q_W-1:0] lut;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] p;
        logic [63:0] mag;
        lut = '0;
        for (int k = 0; k < QTR_ENTRIES; k++) begin
            x   = (64'(4 * k) << 30) / 64'(SINE_ENTRIES);
            x2  = (x * x) >> 30;
            p   = 64'd5026980 - ((64'd172271 * x2) >> 30);
            p   = 64'd85568393 - ((p * x2) >> 30);
            p   = 64'd693598337 - ((p * x2) >> 30);
            p   = 64'd1686629713 - ((p * x2) >> 30);
            p   = (p * x) >> 30;
            mag = (p * 64'd32767 + (64'd1 << 29)) >> 30;
            if (mag > 64'd32767) begin
                mag = 64'd32767;
            end
            lut[k*Q_W +: Q_W] = mag[Q_W-1:0];
        end
        return lut;
    endfunction

    localparam logic [PERIOD_COUNT*PHASE_BITS-1:0] STEP_LUT = build_step_lut();
    localparam logic [QTR_ENTRIES*Q_W-1:0]         SINE_QTR = build_sine_qtr();

endpackage

// ----- rtl/core/ism_channels.sv -----
// ----------------------------------------------------------------------------
// Idle sine modulator channels
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface ism_item_if;
    logic                              valid;
    logic                              ready;
    logic [ism_pkg::RPM_W-1:0]         engine_speed;
    logic [ism_pkg::TPS_W-1:0]         throttle_percent;
    logic signed [ism_pkg::CLT_W-1:0]  coolant_temp;
    logic                              engine_running;

    modport source (output valid, engine_speed, throttle_percent, coolant_temp,
                    engine_running, input ready);
    modport sink   (input valid, engine_speed, throttle_percent, coolant_temp,
                    engine_running, output ready);
endinterface

interface ism_result_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ism_pkg::EFFECT_W-1:0]  effect_value;
    logic signed [ism_pkg::TIMING_W-1:0]  timing_offset;
    logic [ism_pkg::FUEL_W-1:0]           fuel_factor;
    logic                                 skip_spark;

    modport source (output valid, effect_value, timing_offset, fuel_factor, skip_spark,
                    input ready);
    modport sink   (input valid, effect_value, timing_offset, fuel_factor, skip_spark,
                    output ready);
endinterface

interface ism_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ism_pkg::CFG_IDX_W-1:0]   index;
    logic [ism_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/idle_sine_modulator.sv -----
// ----------------------------------------------------------------------------
// Idle sine modulator
// Idle detection, phase advance, sine lookup and timing/fuel/spark outputs.
// ----------------------------------------------------------------------------
// Use: one input item per engine tick arrives on i_item (engine speed, throttle,
// coolant temperature, running flag); one result item per input leaves on
// o_result (scaled sine effect, timing offset, fuel factor, spark skip flag).
// Registers are written through i_cfg, index per register, one write a cycle,
// always ready; write them only while no item is in flight.
// Work is done by a microcoded sequencer: a step counter walks a small control
// ROM whose words steer one shared multiplier and the result registers, with
// conditional jumps that leave out the sine and fuel steps where not needed.
// Off idle the program runs only its check and emit steps; at idle it also runs
// the sine and timing steps, and the fuel steps only with a fuel method. An item
// is accepted only while the sequencer is free, so no new item is taken before the
// last one has been emitted; the shared multiplier gives one product per step.
// The result register decouples the two sides: a stalled receiver holds the
// result on o_result and the next item is still taken and worked on; the
// sequencer then holds at its last step until the result register frees.
// Reset (synchronous, active low) clears the phase, loads register defaults
// and empties the sequencer and result register.
// ----------------------------------------------------------------------------
module idle_sine_modulator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ism_item_if.sink    i_item,
    ism_cfg_if.sink     i_cfg,
    ism_result_if.source o_result
);
    import ism_pkg::*;

    // configuration
    logic                       r_rumble_enable;
    logic [AMP_W-1:0]           r_amplitude;
    logic [PERIOD_W-1:0]        r_period;
    t_method                    r_method;
    logic signed [TSPAN_W-1:0]  r_tspan;
    logic signed [FSPAN_W-1:0]  r_fspan;
    logic [RPMLIM_W-1:0]        r_rpm_limit;
    logic [TPSLIM_W-1:0]        r_tps_limit;

    // sequencer
    logic       r_busy;
    t_step      r_pc;
    t_step      n_pc;
    t_uop       uop;
    logic       jump;
    logic       can_emit;

    // latched item
    logic [RPM_W-1:0]         r_rpm;
    logic [TPS_W-1:0]         r_tps;
    logic signed [CLT_W-1:0]  r_clt;
    logic                     r_run;
    logic                     idle;

    // datapath
    logic [PHASE_BITS-1:0]      r_phase;
    logic [PHASE_BITS-1:0]      n_phase;
    logic [MUL_P_W-1:0]         r_prod;
    logic [Q_W-1:0]             r_mag;
    logic                       r_neg;
    logic                       r_skip;
    logic signed [TIMING_W-1:0] r_tim;
    logic [FUEL_W-1:0]          r_fuel;

    logic [SINE_BITS-1:0]       sine_idx;
    logic [1:0]                 sine_quad;
    logic [QTR_BITS-1:0]        sine_k;
    logic [Q_W-1:0]             sine_mag;
    logic [AMP_W-1:0]           amp_sat;
    logic signed [TSPAN_W-1:0]  tspan_clamp;
    logic [TSPAN_W-1:0]         tspan_abs;
    logic signed [FSPAN_W-1:0]  fspan_clamp;
    logic [FSPAN_W-1:0]         fspan_abs;
    logic [Q_W-1:0]             quo;
    logic [FUEL_PROD_W-1:0]     fuel_sum;
    logic [TIM_PROD_W-1:0]      tim_sum;
    logic [TIMING_W-1:0]        tim_mag;
    logic [MUL_A_W-1:0]         mul_a;
    logic [MUL_B_W-1:0]         mul_b;
    logic [MUL_P_W-1:0]         mul_p;
    logic                       timing_on;
    logic                       fuel_on;

    // result register
    logic                       r_out_valid;
    logic signed [EFFECT_W-1:0] r_out_effect;
    logic signed [TIMING_W-1:0] r_out_timing;
    logic [FUEL_W-1:0]          r_out_fuel;
    logic                       r_out_skip;

    // ------------------------------------------------------------------
    // Control word and idle decision
    // ------------------------------------------------------------------
    assign uop = uop_rom(r_pc);

    assign idle = r_rumble_enable
               && (r_rpm <= RPM_W'(r_rpm_limit))
               && (r_tps <= TPS_W'(r_tps_limit))
               && r_run
               && (r_clt >= CLT_W'(WARM_TEMP));

    assign timing_on = (r_method == METH_TIMING) || (r_method == METH_BOTH);
    assign fuel_on   = (r_method == METH_FUEL)   || (r_method == METH_BOTH);
    assign can_emit  = !r_out_valid || o_result.ready;

    always_comb begin
        case (uop.cond)
            C_NOT_IDLE: jump = !idle;
            C_NO_FUEL:  jump = !fuel_on;
            default:    jump = 1'b0;
        endcase
    end

    always_comb begin
        if (uop.emit) begin
            n_pc = can_emit ? ST_CHECK : r_pc;
        end else if (jump) begin
            n_pc = uop.target;
        end else begin
            n_pc = t_step'(3'(r_pc) + 3'd1);
        end
    end

    // ------------------------------------------------------------------
    // Phase advance and sine lookup: quadrant picks mirror and sign
    // ------------------------------------------------------------------
    assign n_phase   = idle ? r_phase + STEP_LUT[r_period*PHASE_BITS +: PHASE_BITS]
                            : '0;
    assign sine_idx  = r_phase[PHASE_BITS-1 -: SINE_BITS];
    assign sine_quad = sine_idx[SINE_BITS-1 -: 2];
    assign sine_k    = sine_quad[0]
                     ? QTR_BITS'(QTR_SIZE) - QTR_BITS'(sine_idx[SINE_BITS-3:0])
                     : QTR_BITS'(sine_idx[SINE_BITS-3:0]);
    assign sine_mag  = SINE_QTR[sine_k*Q_W +: Q_W];

    // saturate amplitude and spans, split spans into sign and magnitude
    assign amp_sat = (r_amplitude > AMP_W'(AMP_MAX)) ? AMP_W'(AMP_MAX) : r_amplitude;

    always_comb begin
        if (r_tspan > TSPAN_W'(TSPAN_MAX)) begin
            tspan_clamp = TSPAN_W'(TSPAN_MAX);
        end else if (r_tspan < -TSPAN_W'(TSPAN_MAX)) begin
            tspan_clamp = -TSPAN_W'(TSPAN_MAX);
        end else begin
            tspan_clamp = r_tspan;
        end
        if (r_fspan > FSPAN_W'(FSPAN_MAX)) begin
            fspan_clamp = FSPAN_W'(FSPAN_MAX);
        end else if (r_fspan < -FSPAN_W'(FSPAN_MAX)) begin
            fspan_clamp = -FSPAN_W'(FSPAN_MAX);
        end else begin
            fspan_clamp = r_fspan;
        end
    end

    assign tspan_abs = tspan_clamp[TSPAN_W-1] ? -tspan_clamp : tspan_clamp;
    assign fspan_abs = fspan_clamp[FSPAN_W-1] ? -fspan_clamp : fspan_clamp;

    // quotient of the last reciprocal product, i.e. floor(x / 100)
    assign quo      = r_prod[DIV_SHIFT +: Q_W];
    assign fuel_sum = r_prod[FUEL_PROD_W-1:0] + FUEL_PROD_W'(BIAS_200);
    assign tim_sum  = r_prod[TIM_PROD_W-1:0] + TIM_PROD_W'(TIM_BIAS);
    assign tim_mag  = TIMING_W'(tim_sum[TIM_PROD_W-1:TIM_SHIFT]);

    // ------------------------------------------------------------------
    // Shared multiplier, operands chosen by the control word
    // ------------------------------------------------------------------
    always_comb begin
        case (uop.asel)
            A_SINE:   mul_a = MUL_A_W'(sine_mag);
            A_RND100: mul_a = r_prod[MUL_A_W-1:0] + MUL_A_W'(BIAS_100);
            A_QUO:    mul_a = MUL_A_W'(quo);
            A_MAG:    mul_a = MUL_A_W'(r_mag);
            A_RND200: mul_a = MUL_A_W'(fuel_sum[FUEL_PROD_W-1:1]);
            default:  mul_a = '0;
        endcase
        case (uop.bsel)
            B_AMP:   mul_b = MUL_B_W'(amp_sat);
            B_RECIP: mul_b = MUL_B_W'(DIV100_MUL);
            B_TSPAN: mul_b = MUL_B_W'(tspan_abs[TSPAN_MAG_W-1:0]);
            B_FSPAN: mul_b = MUL_B_W'(fspan_abs[FSPAN_MAG_W-1:0]);
            default: mul_b = '0;
        endcase
    end

    assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

    // ------------------------------------------------------------------
    // Control state: configuration, sequencer, phase, result valid
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rumble_enable <= 1'b0;
            r_amplitude     <= AMP_W'(50);
            r_period        <= PERIOD_W'(5);
            r_method        <= METH_BOTH;
            r_tspan         <= TSPAN_W'(4);
            r_fspan         <= FSPAN_W'(10);
            r_rpm_limit     <= RPMLIM_W'(1500);
            r_tps_limit     <= TPSLIM_W'(5);
            r_busy          <= 1'b0;
            r_pc            <= ST_CHECK;
            r_phase         <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (t_reg_idx'(i_cfg.index))
                    REG_RUMBLE_ENABLE:  r_rumble_enable <= i_cfg.data[0];
                    REG_AMPLITUDE:      r_amplitude     <= i_cfg.data[AMP_W-1:0];
                    REG_PERIOD:         r_period        <= i_cfg.data[PERIOD_W-1:0];
                    REG_METHOD:         r_method        <= t_method'(i_cfg.data[1:0]);
                    REG_TIMING_SPAN:    r_tspan         <= i_cfg.data[TSPAN_W-1:0];
                    REG_FUEL_SPAN:      r_fspan         <= i_cfg.data[FSPAN_W-1:0];
                    REG_RPM_LIMIT:      r_rpm_limit     <= i_cfg.data[RPMLIM_W-1:0];
                    REG_THROTTLE_LIMIT: r_tps_limit     <= i_cfg.data[TPSLIM_W-1:0];
                endcase
            end

            // load a fresh result, else drop the one taken by the receiver
            if (r_busy && uop.emit && can_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            if (!r_busy) begin
                if (i_item.valid) begin
                    r_busy <= 1'b1;
                    r_pc   <= ST_CHECK;
                end
            end else begin
                r_pc <= n_pc;
                if (uop.ld_phase) begin
                    r_phase <= n_phase;
                end
                if (uop.emit && can_emit) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload: latched item, working registers, result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!r_busy && i_item.valid) begin
            // latch the item and preset neutral outputs
            r_rpm  <= i_item.engine_speed;
            r_tps  <= i_item.throttle_percent;
            r_clt  <= i_item.coolant_temp;
            r_run  <= i_item.engine_running;
            r_mag  <= '0;
            r_neg  <= 1'b0;
            r_skip <= 1'b0;
            r_tim  <= '0;
            r_fuel <= FUEL_W'(FUEL_NEUTRAL);
        end else if (r_busy) begin
            if (uop.mul_en) begin
                r_prod <= mul_p;
            end
            if (uop.ld_sign) begin
                r_neg <= sine_quad[1];
            end
            if (uop.ld_mag) begin
                r_mag  <= quo;
                r_skip <= (r_method == METH_SPARK) && r_neg && (quo >= Q_W'(SKIP_MAG_MIN));
            end
            if (uop.ld_tim && timing_on) begin
                r_tim <= (r_neg ^ tspan_clamp[TSPAN_W-1]) ? -tim_mag : tim_mag;
            end
            if (uop.ld_fuel) begin
                r_fuel <= (r_neg ^ fspan_clamp[FSPAN_W-1])
                        ? FUEL_W'(FUEL_NEUTRAL) - quo
                        : FUEL_W'(FUEL_NEUTRAL) + quo;
            end
            if (uop.emit && can_emit) begin
                r_out_effect <= r_neg ? -EFFECT_W'(r_mag) : EFFECT_W'(r_mag);
                r_out_timing <= r_tim;
                r_out_fuel   <= r_fuel;
                r_out_skip   <= r_skip;
            end
        end
    end

    assign i_item.ready          = !r_busy;
    assign i_cfg.ready           = 1'b1;
    assign o_result.valid        = r_out_valid;
    assign o_result.effect_value = r_out_effect;
    assign o_result.timing_offset = r_out_timing;
    assign o_result.fuel_factor  = r_out_fuel;
    assign o_result.skip_spark   = r_out_skip;

`ifndef NO_ASSERTIONS
    // a free sequencer always sits at its first step
    a_free_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_pc == ST_CHECK)
        else $error("sequencer free away from its first step");

    // an accepted item starts the program
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> (r_busy && r_pc == ST_CHECK))
        else $error("accepted item did not start the program");

    // a spark skip only goes with a negative effect
    a_skip_negative: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_skip) |-> r_out_effect[EFFECT_W-1])
        else $error("spark skip with non-negative effect");

    // a zero effect leaves timing and fuel neutral
    a_zero_neutral: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_effect == '0)
            |-> (r_out_timing == '0 && r_out_fuel == FUEL_W'(FUEL_NEUTRAL)))
        else $error("zero effect with non-neutral timing or fuel");
`endif

endmodule

// ----- tb/ism_tick_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Idle sine modulator tick checker
// Follows register writes, predicts one result item per accepted input item
// and compares every accepted result item with the oldest prediction.
// ----------------------------------------------------------------------------
module ism_tick_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ism_item_if   i_item,
    ism_cfg_if    i_cfg,
    ism_result_if i_result,
    output int    o_pending,
    output int    o_failures
);
    import ism_pkg::*;

    typedef struct packed {
        logic signed [EFFECT_W-1:0] effect;
        logic signed [TIMING_W-1:0] timing;
        logic [FUEL_W-1:0]          fuel;
        logic                       skip;
    } t_tick_out;

    // (pi/2)^n / n! in Q30
    localparam longint unsigned COEF_X1 = 64'd1686629713;
    localparam longint unsigned COEF_X3 = 64'd693598337;
    localparam longint unsigned COEF_X5 = 64'd85568393;
    localparam longint unsigned COEF_X7 = 64'd5026980;
    localparam longint unsigned COEF_X9 = 64'd172271;

    logic                     en_now;
    logic [AMP_W-1:0]         amp_now;
    logic [PERIOD_W-1:0]      per_now;
    t_method                  meth_now;
    logic signed [TSPAN_W-1:0] tspan_now;
    logic signed [FSPAN_W-1:0] fspan_now;
    logic [RPMLIM_W-1:0]      rpm_lim_now;
    logic [TPSLIM_W-1:0]      tps_lim_now;
    logic [PHASE_BITS-1:0]    phase_now;

    t_tick_out expected_ticks[$];
    int        fail_tally = 0;

    assign o_failures = fail_tally;

    // Q1.15 sine of the phase, built from the degree-9 polynomial per quarter
    function automatic longint wave_q15(input logic [PHASE_BITS-1:0] ph);
        longint unsigned idx, t, quad, rem, x, x2, p, mag;
        idx  = ph;
        idx  = (idx * SINE_ENTRIES) >> PHASE_BITS;
        t    = idx * 4;
        quad = t / SINE_ENTRIES;
        rem  = t % SINE_ENTRIES;
        if (quad % 2 == 1) begin
            rem = SINE_ENTRIES - rem;
        end
        x   = (rem << 30) / SINE_ENTRIES;
        x2  = (x * x) >> 30;
        p   = COEF_X7 - ((COEF_X9 * x2) >> 30);
        p   = COEF_X5 - ((p * x2) >> 30);
        p   = COEF_X3 - ((p * x2) >> 30);
        p   = COEF_X1 - ((p * x2) >> 30);
        p   = (p * x) >> 30;
        mag = (p * 32767 + (64'd1 << 29)) >> 30;
        if (mag > 32767) begin
            mag = 32767;
        end
        return (quad >= 2) ? -longint'(mag) : longint'(mag);
    endfunction

    // divide, rounding half away from zero
    function automatic longint rnd_div(input longint num, input longint den);
        longint mag;
        mag = (num < 0) ? -num : num;
        mag = (mag + den / 2) / den;
        return (num < 0) ? -mag : mag;
    endfunction

    function automatic t_tick_out predict_tick(input logic [RPM_W-1:0] rpm,
                                               input logic [TPS_W-1:0] tps,
                                               input logic signed [CLT_W-1:0] clt,
                                               input logic run);
        t_tick_out r;
        logic      idle;
        longint    per_eff, step, amp_eff, eff, ts, fs, timing, fuel;
        idle   = en_now && (rpm <= rpm_lim_now) && (tps <= tps_lim_now) && run &&
                 (clt >= WARM_TEMP);
        eff    = 0;
        timing = 0;
        fuel   = FUEL_NEUTRAL;
        r.skip = 1'b0;
        if (!idle) begin
            phase_now = '0;
        end else begin
            per_eff   = (per_now == 0) ? 1 : per_now;
            step      = ((64'd1 << PHASE_BITS) + 5 * per_eff) / (10 * per_eff);
            phase_now = phase_now + PHASE_BITS'(step);
            amp_eff   = (amp_now > AMP_MAX) ? AMP_MAX : amp_now;
            eff       = rnd_div(wave_q15(phase_now) * amp_eff, 100);
            ts        = tspan_now;
            ts        = (ts < -TSPAN_MAX) ? -TSPAN_MAX : ((ts > TSPAN_MAX) ? TSPAN_MAX : ts);
            fs        = fspan_now;
            fs        = (fs < -FSPAN_MAX) ? -FSPAN_MAX : ((fs > FSPAN_MAX) ? FSPAN_MAX : fs);
            if (meth_now == METH_TIMING || meth_now == METH_BOTH) begin
                timing = rnd_div(eff * ts, 128);
            end
            if (meth_now == METH_FUEL || meth_now == METH_BOTH) begin
                fuel = FUEL_NEUTRAL + rnd_div(eff * fs, 200);
            end
            r.skip = (meth_now == METH_SPARK) && (eff * 10 < -7 * 32768);
        end
        r.effect = EFFECT_W'(eff);
        r.timing = TIMING_W'(timing);
        r.fuel   = FUEL_W'(fuel);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_tick_out got, want;
        if (!i_rst_n) begin
            en_now      = 1'b0;
            amp_now     = 7'd50;
            per_now     = 5'd5;
            meth_now    = METH_BOTH;
            tspan_now   = 5'sd4;
            fspan_now   = 6'sd10;
            rpm_lim_now = 11'd1500;
            tps_lim_now = 5'd5;
            phase_now   = '0;
            expected_ticks.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_reg_idx'(i_cfg.index))
                    REG_RUMBLE_ENABLE:  en_now      = i_cfg.data[0];
                    REG_AMPLITUDE:      amp_now     = i_cfg.data[AMP_W-1:0];
                    REG_PERIOD:         per_now     = i_cfg.data[PERIOD_W-1:0];
                    REG_METHOD:         meth_now    = t_method'(i_cfg.data[1:0]);
                    REG_TIMING_SPAN:    tspan_now   = i_cfg.data[TSPAN_W-1:0];
                    REG_FUEL_SPAN:      fspan_now   = i_cfg.data[FSPAN_W-1:0];
                    REG_RPM_LIMIT:      rpm_lim_now = i_cfg.data[RPMLIM_W-1:0];
                    REG_THROTTLE_LIMIT: tps_lim_now = i_cfg.data[TPSLIM_W-1:0];
                    default: ;
                endcase
            end
            if (i_item.valid && i_item.ready) begin
                expected_ticks.push_back(predict_tick(i_item.engine_speed,
                                                      i_item.throttle_percent,
                                                      i_item.coolant_temp,
                                                      i_item.engine_running));
            end
            if (i_result.valid && i_result.ready) begin
                got.effect = i_result.effect_value;
                got.timing = i_result.timing_offset;
                got.fuel   = i_result.fuel_factor;
                got.skip   = i_result.skip_spark;
                if (expected_ticks.size() == 0) begin
                    $error("result item with no input item waiting");
                    fail_tally++;
                end else begin
                    want = expected_ticks.pop_front();
                    if (got.effect !== want.effect) begin
                        $error("effect_value: expected %0d, got %0d", want.effect, got.effect);
                        fail_tally++;
                    end
                    if (got.timing !== want.timing) begin
                        $error("timing_offset: expected %0d, got %0d", want.timing, got.timing);
                        fail_tally++;
                    end
                    if (got.fuel !== want.fuel) begin
                        $error("fuel_factor: expected %0d, got %0d", want.fuel, got.fuel);
                        fail_tally++;
                    end
                    if (got.skip !== want.skip) begin
                        $error("skip_spark: expected %0b, got %0b", want.skip, got.skip);
                        fail_tally++;
                    end
                end
            end
        end
        o_pending <= expected_ticks.size();
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Idle sine modulator testbench
// Drives register settings and engine ticks into the modulator, stalls the
// result side at random, and leaves prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module testbench;
    import ism_pkg::*;

    localparam int RAND_PHASES     = 12;
    localparam int TICKS_PER_PHASE = 152;
    localparam int CALM_PHASE      = 6;
    localparam int IDLE_PCT        = 29;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    ism_item_if   item_ch ();
    ism_cfg_if    cfg_ch ();
    ism_result_if res_ch ();

    int pending;
    int failures;

    // limits in force, used to shape ticks that sit inside the idle window
    logic [RPMLIM_W-1:0] cur_rpm_lim = 11'd1500;
    logic [TPSLIM_W-1:0] cur_tps_lim = 5'd5;
    // while set, neither side idles
    logic                calm        = 1'b0;

    idle_sine_modulator i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .i_cfg    (cfg_ch),
        .o_result (res_ch)
    );

    ism_tick_checker u_tick_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_ch),
        .i_cfg      (cfg_ch),
        .i_result   (res_ch),
        .o_pending  (pending),
        .o_failures (failures)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // receiver: stall at random, except through the calm stretch
    always @(negedge i_clk) begin
        res_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // write one register; return at the falling edge after the write lands
    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        @(negedge i_clk);
    endtask

    // write the whole register set; call only with nothing in flight
    task automatic write_settings(input logic en, input logic [AMP_W-1:0] amp,
                                  input logic [PERIOD_W-1:0] per, input t_method meth,
                                  input logic [TSPAN_W-1:0] ts, input logic [FSPAN_W-1:0] fs,
                                  input logic [RPMLIM_W-1:0] rl,
                                  input logic [TPSLIM_W-1:0] tl);
        write_reg(REG_RUMBLE_ENABLE, CFG_DATA_W'(en));
        write_reg(REG_AMPLITUDE, CFG_DATA_W'(amp));
        write_reg(REG_PERIOD, CFG_DATA_W'(per));
        write_reg(REG_METHOD, CFG_DATA_W'(meth));
        write_reg(REG_TIMING_SPAN, CFG_DATA_W'(ts));
        write_reg(REG_FUEL_SPAN, CFG_DATA_W'(fs));
        write_reg(REG_RPM_LIMIT, CFG_DATA_W'(rl));
        write_reg(REG_THROTTLE_LIMIT, CFG_DATA_W'(tl));
        cfg_ch.valid = 1'b0;
        cur_rpm_lim  = rl;
        cur_tps_lim  = tl;
    endtask

    // offer one tick after an optional random gap; return at the falling edge
    // after acceptance, valid still high so back-to-back items stay seamless
    task automatic send_tick(input logic [RPM_W-1:0] rpm, input logic [TPS_W-1:0] tps,
                             input logic signed [CLT_W-1:0] clt, input logic run);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            item_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        item_ch.valid            = 1'b1;
        item_ch.engine_speed     = rpm;
        item_ch.throttle_percent = tps;
        item_ch.coolant_temp     = clt;
        item_ch.engine_running   = run;
        do @(posedge i_clk); while (!(item_ch.valid && item_ch.ready));
        @(negedge i_clk);
    endtask

    // hold the sender until every predicted result has come back
    task automatic drain_results();
        item_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // random register set with a bias towards the extremes and the
    // out-of-range values that the block saturates
    task automatic pick_settings(input t_method meth);
        logic                en;
        logic [AMP_W-1:0]    amp;
        logic [PERIOD_W-1:0] per;
        logic [TSPAN_W-1:0]  ts;
        logic [FSPAN_W-1:0]  fs;
        logic [RPMLIM_W-1:0] rl;
        logic [TPSLIM_W-1:0] tl;
        en = ($urandom_range(9) != 0);
        case ($urandom_range(4))
            0:       amp = '0;
            1:       amp = AMP_W'(AMP_MAX);
            2:       amp = '1;
            default: amp = AMP_W'($urandom_range(AMP_MAX));
        endcase
        case ($urandom_range(4))
            0:       per = '0;
            1:       per = PERIOD_W'(1);
            2:       per = '1;
            default: per = PERIOD_W'($urandom_range(20, 1));
        endcase
        case ($urandom_range(3))
            0:       ts = {1'b1, {(TSPAN_W-1){1'b0}}};
            1:       ts = {1'b0, {(TSPAN_W-1){1'b1}}};
            default: ts = TSPAN_W'($urandom);
        endcase
        case ($urandom_range(3))
            0:       fs = {1'b1, {(FSPAN_W-1){1'b0}}};
            1:       fs = {1'b0, {(FSPAN_W-1){1'b1}}};
            default: fs = FSPAN_W'($urandom);
        endcase
        case ($urandom_range(5))
            0:       rl = '0;
            1:       rl = '1;
            default: rl = RPMLIM_W'($urandom_range(2000, 300));
        endcase
        case ($urandom_range(5))
            0:       tl = '0;
            1:       tl = '1;
            default: tl = TPSLIM_W'($urandom_range(20));
        endcase
        write_settings(en, amp, per, meth, ts, fs, rl, tl);
    endtask

    // mostly long runs of idle ticks so the phase walks far round the wave,
    // broken now and then by a tick that falls out of idle or by plain noise
    task automatic run_ticks(input int count);
        int                       sent;
        int                       burst;
        int                       v;
        logic [RPM_W-1:0]         rpm;
        logic [TPS_W-1:0]         tps;
        logic signed [CLT_W-1:0]  clt;
        logic                     run;
        sent  = 0;
        burst = $urandom_range(250, 1);
        while (sent < count) begin
            rpm = ($urandom_range(7) == 0) ? RPM_W'(cur_rpm_lim)
                                           : RPM_W'($urandom_range(cur_rpm_lim));
            tps = ($urandom_range(7) == 0) ? TPS_W'(cur_tps_lim)
                                           : TPS_W'($urandom_range(cur_tps_lim));
            clt = ($urandom_range(7) == 0) ? CLT_W'(WARM_TEMP)
                                           : CLT_W'($urandom_range(255, WARM_TEMP));
            run = 1'b1;
            if (burst > 0) begin
                burst--;
            end else begin
                // knock the tick out of idle in one way, then pick the next run
                case ($urandom_range(4))
                    0: rpm = RPM_W'($urandom_range(16383, cur_rpm_lim + 1));
                    1: tps = TPS_W'($urandom_range(127, cur_tps_lim + 1));
                    2: begin
                        v   = int'($urandom_range(315)) - 256;
                        clt = CLT_W'(v);
                    end
                    3: run = 1'b0;
                    default: begin
                        rpm = RPM_W'($urandom);
                        tps = TPS_W'($urandom);
                        clt = CLT_W'($urandom);
                        run = 1'($urandom);
                    end
                endcase
                burst = ($urandom_range(3) == 0) ? 0 : $urandom_range(250, 1);
            end
            send_tick(rpm, tps, clt, run);
            sent++;
        end
    endtask

    initial begin
        item_ch.valid            = 1'b0;
        item_ch.engine_speed     = '0;
        item_ch.throttle_percent = '0;
        item_ch.coolant_temp     = '0;
        item_ch.engine_running   = 1'b0;
        cfg_ch.valid             = 1'b0;
        cfg_ch.index             = REG_RUMBLE_ENABLE;
        cfg_ch.data              = '0;
        res_ch.ready             = 1'b0;

        // hold reset, then drop it at a falling edge
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: modulation off, so even idle ticks give neutral output
        send_tick(14'd1000, 7'd3, 9'sd90, 1'b1);
        send_tick(14'd0, 7'd0, 9'sd60, 1'b1);
        send_tick(14'h3FFF, 7'h7F, 9'sh100, 1'b0);
        drain_results();

        // full amplitude, shortest period, both timing and fuel, widest spans
        write_settings(1'b1, 7'd100, 5'd1, METH_BOTH, 5'sd10, 6'sd20, 11'd2000, 5'd20);
        send_tick(14'd2000, 7'd20, 9'sd215, 1'b1);
        send_tick(14'd0, 7'd0, 9'sd60, 1'b1);
        send_tick(14'd1200, 7'd5, 9'sd255, 1'b1);
        send_tick(14'd900, 7'd0, 9'sd80, 1'b1);
        send_tick(14'd900, 7'd0, 9'sd80, 1'b1);
        // each idle condition broken on its own, then every field at its extreme
        send_tick(14'd2001, 7'd20, 9'sd80, 1'b1);
        send_tick(14'd800, 7'd21, 9'sd80, 1'b1);
        send_tick(14'd800, 7'd0, 9'sd59, 1'b1);
        send_tick(14'd800, 7'd0, 9'sd80, 1'b0);
        send_tick(14'h3FFF, 7'h7F, 9'sh100, 1'b1);
        send_tick(14'd0, 7'd0, -9'sd1, 1'b1);
        send_tick(14'd500, 7'd10, 9'sd100, 1'b1);
        drain_results();

        // spark cut with saturating amplitude and spans, period zero; ten idle
        // ticks go once round the wave and wrap the phase
        write_settings(1'b1, 7'd127, 5'd0, METH_SPARK, 5'b10000, 6'b011111, 11'h7FF, 5'h1F);
        repeat (10) send_tick(14'd1000, 7'd10, 9'sd90, 1'b1);
        drain_results();

        // random phases, each with fresh settings and every method in turn
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            calm = (ph == CALM_PHASE);
            pick_settings(t_method'(ph % 4));
            run_ticks(TICKS_PER_PHASE);
            drain_results();
        end
        calm = 1'b0;

        // let any stray result surface before the verdict
        repeat (20) @(negedge i_clk);
        if (failures == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // watchdog: well beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
